// File: hdl/hka_pkg.sv
// ----------------------------------------------------------------------------
// hka_pkg
// Shared types and constants for the held key autorepeat block.
// ----------------------------------------------------------------------------
package hka_pkg;

    localparam int MAX_HELD_DEF = 8;
    localparam int KEY_W        = 29;
    localparam int CNT_W        = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_W-1:0] HOLD_DELAY_RST    = 16'd600;
    localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 16'd40;
    localparam logic [CNT_W-1:0] CNT_SAT           = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_DELAY    = 1'd0,
        CFG_REPEAT_PERIOD = 1'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_PRESS   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_REPEAT  = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_QUERY   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // item travelling down the row, one cell per cycle
    typedef struct packed {
        logic             vld;
        t_cmd             cmd;
        logic [KEY_W-1:0] key;
        logic             found;
        logic             placed;
        logic             pend_vld;
        logic [KEY_W-1:0] pend_key;
    } t_token;

    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] age;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
    } t_emit;

endpackage

// File: hdl/hka_cell.sv
// ----------------------------------------------------------------------------
// hka_cell
// One table slot: holds a key entry, works on the passing item and hands
// the item and, on release, its entry to its neighbors.
// ----------------------------------------------------------------------------
module hka_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hka_pkg::t_token             i_tok,
    output hka_pkg::t_token             o_tok,
    input  hka_pkg::t_entry             i_right,
    input  logic                        i_right_shift,
    output hka_pkg::t_entry             o_entry,
    output logic                        o_shift,
    input  logic [hka_pkg::CFG_W-1:0]   i_hold_delay,
    input  logic [hka_pkg::CFG_W-1:0]   i_repeat_period,
    output hka_pkg::t_emit              o_emit
);
    import hka_pkg::*;

    t_token            r_tok;
    t_token            n_tok;
    t_entry            r_entry;
    t_entry            n_entry;
    t_emit             emit;
    logic              match;
    logic [CNT_W-1:0]  age_inc;
    logic [CNT_W-1:0]  cnt_inc;

    assign match   = r_entry.vld && (r_entry.key == i_tok.key);
    assign age_inc = (r_entry.age == CNT_SAT) ? r_entry.age : r_entry.age + 1'b1;
    assign cnt_inc = (r_entry.cnt == CNT_SAT) ? r_entry.cnt : r_entry.cnt + 1'b1;
    assign o_shift = i_tok.vld && (i_tok.cmd == CMD_RELEASE) && i_tok.found;

    always_comb begin
        n_tok   = i_tok;
        n_entry = r_entry;
        emit    = '0;
        if (i_right_shift) begin
            n_entry = i_right;
        end
        if (i_tok.vld) begin
            case (i_tok.cmd)
                CMD_PRESS: begin
                    if (match) begin
                        n_tok.found = 1'b1;
                    end else if (!r_entry.vld && !i_tok.found && !i_tok.placed) begin
                        n_entry.vld = 1'b1;
                        n_entry.key = i_tok.key;
                        n_entry.age = '0;
                        n_entry.cnt = '0;
                        n_tok.placed = 1'b1;
                    end
                end
                CMD_RELEASE: begin
                    // slot vacated; refilled next cycle from the right
                    if (i_tok.found || match) begin
                        n_entry.vld = 1'b0;
                    end
                    if (match) begin
                        n_tok.found = 1'b1;
                    end
                end
                CMD_QUERY: begin
                    if (match) begin
                        n_tok.found = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (r_entry.vld) begin
                        n_entry.age = age_inc;
                        if (age_inc > i_hold_delay) begin
                            n_entry.cnt = cnt_inc;
                            if (cnt_inc >= i_repeat_period) begin
                                n_entry.cnt = '0;
                                // previous repeat goes out now, this one waits
                                emit.vld       = i_tok.pend_vld;
                                emit.key       = i_tok.pend_key;
                                n_tok.pend_vld = 1'b1;
                                n_tok.pend_key = r_entry.key;
                            end
                        end
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok       <= '0;
            r_entry.vld <= 1'b0;
        end else begin
            r_tok       <= n_tok;
            r_entry.vld <= n_entry.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.key <= n_entry.key;
        r_entry.age <= n_entry.age;
        r_entry.cnt <= n_entry.cnt;
    end

    assign o_tok   = r_tok;
    assign o_entry = r_entry;
    assign o_emit  = emit;

endmodule

// File: hdl/held_key_autorepeat.sv
// ----------------------------------------------------------------------------
// held_key_autorepeat
// Typematic repeat for held keys: an ordered table of held keys kept in a
// row of cells, with press, release, query and millisecond tick commands.
// ----------------------------------------------------------------------------
// Each item runs from start to its final result (last = 1); busy stays high until
// it leaves the row, so no new item is taken before then. The item walks the cell row
// one cell per cycle. Tick repeats come out at most one per cycle, in table order.
// Reset clears all entries and loads hold_delay 600, repeat_period 40.
// Results are one-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
module held_key_autorepeat #(
    parameter int MAX_HELD = hka_pkg::MAX_HELD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_command,
    input  logic [hka_pkg::KEY_W-1:0]     i_key,
    input  logic                          i_cfg_we,
    input  logic [hka_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hka_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output logic [1:0]                    o_kind,
    output logic [hka_pkg::KEY_W-1:0]     o_key_out,
    output logic [1:0]                    o_status,
    output logic                          o_last
);
    import hka_pkg::*;

    t_token             tok   [MAX_HELD+1];
    t_entry             ent   [MAX_HELD+1];
    logic               shift [MAX_HELD+1];
    t_emit              emits [MAX_HELD];
    t_emit              emit_any;
    t_token             fin;
    logic               accept;

    logic               r_busy;
    logic [CFG_W-1:0]   r_hold_delay;
    logic [CFG_W-1:0]   r_repeat_period;
    logic               r_strobe;
    logic               n_strobe;
    logic [1:0]         r_kind;
    logic [1:0]         n_kind;
    logic [KEY_W-1:0]   r_key_out;
    logic [KEY_W-1:0]   n_key_out;
    logic [1:0]         r_status;
    logic [1:0]         n_status;
    logic               r_last;
    logic               n_last;

    assign accept = start && !r_busy;
    assign busy   = r_busy;
    assign fin    = tok[MAX_HELD];

    always_comb begin
        tok[0]          = '0;
        tok[0].vld      = accept;
        tok[0].cmd      = t_cmd'(i_command);
        tok[0].key      = i_key;
        ent[MAX_HELD]   = '0;
        shift[MAX_HELD] = 1'b0;
    end

    for (genvar g = 0; g < MAX_HELD; g++) begin : g_cell
        hka_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_tok           (tok[g]),
            .o_tok           (tok[g+1]),
            .i_right         (ent[g+1]),
            .i_right_shift   (shift[g+1]),
            .o_entry         (ent[g]),
            .o_shift         (shift[g]),
            .i_hold_delay    (r_hold_delay),
            .i_repeat_period (r_repeat_period),
            .o_emit          (emits[g])
        );
    end

    // only the cell holding the item can emit
    always_comb begin
        emit_any = '0;
        for (int i = 0; i < MAX_HELD; i++) begin
            emit_any.vld = emit_any.vld | emits[i].vld;
            emit_any.key = emit_any.key | (emits[i].vld ? emits[i].key : '0);
        end
    end

    always_comb begin
        n_strobe  = 1'b0;
        n_kind    = KIND_REPEAT;
        n_key_out = fin.key;
        n_status  = ST_OK;
        n_last    = 1'b1;
        if (emit_any.vld) begin
            n_strobe  = 1'b1;
            n_key_out = emit_any.key;
            n_last    = 1'b0;
        end else if (fin.vld) begin
            case (fin.cmd)
                CMD_PRESS: begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_PRESS;
                    n_status = fin.found ? ST_MISS : (fin.placed ? ST_OK : ST_FULL);
                end
                CMD_RELEASE: begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_RELEASE;
                    n_status = fin.found ? ST_OK : ST_MISS;
                end
                CMD_QUERY: begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_QUERY;
                    n_status = fin.found ? ST_OK : ST_MISS;
                end
                CMD_TICK: begin
                    n_strobe  = fin.pend_vld;
                    n_key_out = fin.pend_key;
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_strobe        <= 1'b0;
            r_hold_delay    <= HOLD_DELAY_RST;
            r_repeat_period <= REPEAT_PERIOD_RST;
        end else begin
            r_strobe <= n_strobe;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (fin.vld) begin
                r_busy <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HOLD_DELAY:    r_hold_delay    <= i_cfg_data;
                    CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data;
                    default:           r_hold_delay    <= r_hold_delay;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key_out <= n_key_out;
        r_status  <= n_status;
        r_last    <= n_last;
    end

    assign o_strobe  = r_strobe;
    assign o_kind    = r_kind;
    assign o_key_out = r_key_out;
    assign o_status  = r_status;
    assign o_last    = r_last;

endmodule
